// ===== rtl/cad_pkg.sv =====
// ----------------------------------------------------------------------------
// cad_pkg : shared types and constants of the capacitive angle decoder
// Region codes, register indexes, fixed field widths and width helpers.
// ----------------------------------------------------------------------------
package cad_pkg;

	// default parameter values
	localparam int CHANNEL_BITS_DEF = 16;
	localparam int COEF_BITS_DEF    = 20;

	// fixed field widths
	localparam int ANGLE_W   = 20;
	localparam int REGION_W  = 3;
	localparam int OFFSET_W  = 17;
	localparam int EDGE_W    = 18;
	localparam int BIAS_W    = 20;
	localparam int CFG_IDX_W = 3;

	// fixed point constants
	localparam int ROUND_SHIFT     = 6;      // Q.12 degrees to 1/64 degree
	localparam int PROD_LIMIT_LOG2 = 60;     // products clamp at +-2^60
	localparam int FULL_TURN       = 23040;  // 360 degrees in 1/64 units
	localparam int ANGLE_MAX       = 524287;
	localparam int ANGLE_MIN       = -524288;

	// result region
	typedef enum logic [REGION_W-1:0] {
		RGN_WIN_POS = 3'd0,
		RGN_WIN_NEG = 3'd1,
		RGN_BELOW   = 3'd2,
		RGN_ABOVE   = 3'd3,
		RGN_NONE    = 3'd4
	} region_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CURVE_MODE  = 3'd0,
		CFG_ROUGH_OFS   = 3'd1,
		CFG_EDGE_BOUNDS = 3'd2,
		CFG_OUT_BIAS    = 3'd3,
		CFG_SET_ONE     = 3'd4,
		CFG_SET_TWO     = 3'd5,
		CFG_SET_THREE   = 3'd6,
		CFG_SET_FOUR    = 3'd7
	} cfg_idx_t;

	// width of the fine difference B - C
	function automatic int diff_width(input int cb);
		diff_width = cb + 1;
	endfunction

	// width of the curve argument: the rough difference D - A - offset
	function automatic int x_width(input int cb);
		x_width = ((cb + 1 > OFFSET_W) ? cb + 1 : OFFSET_W) + 1;
	endfunction

	// configuration data width
	function automatic int cfg_width(input int cw);
		cfg_width = (3 * cw > 2 * EDGE_W) ? 3 * cw : 2 * EDGE_W;
	endfunction

	localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/capacitive_angle_decoder_core.sv =====
// ----------------------------------------------------------------------------
// capacitive_angle_decoder_core : capacitive angle decoder, top level
// Turns four capacitive channel readings into an angle by a calibrated curve.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive channel_a..channel_d and raise start; the item is taken at a
//   rising edge where start is high and busy is low. One item may follow
//   every cycle.
//   Output: done is high for one cycle with angle (1/64 degree, saturated)
//   and region. The accepting edge loads the front stage; one edge each
//   then loads the queue slot and the five curve evaluation stages, and
//   done rises once the last of them is loaded. The receiver cannot hold
//   results off; the back end never stalls, so the queue drains every cycle
//   and busy stays low.
//   Configuration: cfg_index/cfg_data with cfg_valid; cfg_ready is always
//   high. Write only while no item is in flight.
//   Reset: arst_n zeroes the configuration registers (linear mode, zero
//   edges, offset, bias, coefficients) and valid and fill state; the pipeline empties.
// ----------------------------------------------------------------------------
module capacitive_angle_decoder_core #(
	parameter int CHANNEL_BITS = cad_pkg::CHANNEL_BITS_DEF,
	parameter int COEF_BITS    = cad_pkg::COEF_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	output logic                                       busy,
	input  logic signed [CHANNEL_BITS-1:0]             channel_a,
	input  logic signed [CHANNEL_BITS-1:0]             channel_b,
	input  logic signed [CHANNEL_BITS-1:0]             channel_c,
	input  logic signed [CHANNEL_BITS-1:0]             channel_d,
	output logic                                       done,
	output logic signed [cad_pkg::ANGLE_W-1:0]         angle,
	output logic [cad_pkg::REGION_W-1:0]               region,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [cad_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [cad_pkg::cfg_width(COEF_BITS)-1:0]   cfg_data
);

	localparam int XW    = cad_pkg::x_width(CHANNEL_BITS);
	localparam int Q_W   = XW + cad_pkg::REGION_W;
	localparam int SET_W = 3 * COEF_BITS;

	logic                                   curve_mode_q;
	logic signed [cad_pkg::OFFSET_W-1:0]    rough_offset_q;
	logic [2*cad_pkg::EDGE_W-1:0]           edge_bounds_q;
	logic signed [cad_pkg::BIAS_W-1:0]      output_bias_q;
	logic [3:0][SET_W-1:0]                  curve_sets_q;

	logic                   cfg_write;
	cad_pkg::cfg_idx_t      cfg_idx;
	logic                   q_full;
	logic                   q_push;
	cad_pkg::region_t       front_region;
	logic signed [XW-1:0]   front_x;
	logic                   head_valid;
	logic [Q_W-1:0]         head_data;
	cad_pkg::region_t       back_region;

	// configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign cfg_idx   = cad_pkg::cfg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q   <= 1'b0;
			rough_offset_q <= '0;
			edge_bounds_q  <= '0;
			output_bias_q  <= '0;
			curve_sets_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				cad_pkg::CFG_CURVE_MODE:  curve_mode_q <= cfg_data[0];
				cad_pkg::CFG_ROUGH_OFS:
					rough_offset_q <= $signed(cfg_data[cad_pkg::OFFSET_W-1:0]);
				cad_pkg::CFG_EDGE_BOUNDS:
					edge_bounds_q <= cfg_data[2*cad_pkg::EDGE_W-1:0];
				cad_pkg::CFG_OUT_BIAS:
					output_bias_q <= $signed(cfg_data[cad_pkg::BIAS_W-1:0]);
				cad_pkg::CFG_SET_ONE:     curve_sets_q[0] <= cfg_data[SET_W-1:0];
				cad_pkg::CFG_SET_TWO:     curve_sets_q[1] <= cfg_data[SET_W-1:0];
				cad_pkg::CFG_SET_THREE:   curve_sets_q[2] <= cfg_data[SET_W-1:0];
				cad_pkg::CFG_SET_FOUR:    curve_sets_q[3] <= cfg_data[SET_W-1:0];
				default:                  curve_mode_q <= curve_mode_q;
			endcase
		end
	end

	// accept and classify
	cad_front #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.channel_a    (channel_a),
		.channel_b    (channel_b),
		.channel_c    (channel_c),
		.channel_d    (channel_d),
		.curve_mode   (curve_mode_q),
		.rough_offset (rough_offset_q),
		.edge_bounds  (edge_bounds_q),
		.q_full       (q_full),
		.push         (q_push),
		.region_out   (front_region),
		.x_out        (front_x)
	);

	// decouple front and back
	cad_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  ({front_region, front_x}),
		.full       (q_full),
		.pop        (head_valid),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign back_region = cad_pkg::region_t'(head_data[Q_W-1:XW]);

	// evaluate the curve
	cad_back #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.COEF_BITS    (COEF_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (head_valid),
		.in_region   (back_region),
		.in_x        ($signed(head_data[XW-1:0])),
		.curve_mode  (curve_mode_q),
		.output_bias (output_bias_q),
		.curve_sets  (curve_sets_q),
		.done        (done),
		.angle       (angle),
		.region      (region)
	);

endmodule

// ===== rtl/cad_front.sv =====
// ----------------------------------------------------------------------------
// cad_front : input stage of the capacitive angle decoder
// Forms the fine and rough differences, classifies the item against the edge
// window and holds it in one register until the queue takes it.
// ----------------------------------------------------------------------------
module cad_front #(
	parameter int CHANNEL_BITS = cad_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic signed [CHANNEL_BITS-1:0]            channel_a,
	input  logic signed [CHANNEL_BITS-1:0]            channel_b,
	input  logic signed [CHANNEL_BITS-1:0]            channel_c,
	input  logic signed [CHANNEL_BITS-1:0]            channel_d,
	input  logic                                      curve_mode,
	input  logic signed [cad_pkg::OFFSET_W-1:0]       rough_offset,
	input  logic [2*cad_pkg::EDGE_W-1:0]              edge_bounds,
	input  logic                                      q_full,
	output logic                                      push,
	output cad_pkg::region_t                          region_out,
	output logic signed [cad_pkg::x_width(CHANNEL_BITS)-1:0] x_out
);

	localparam int DIFF_W = cad_pkg::diff_width(CHANNEL_BITS);
	localparam int XW     = cad_pkg::x_width(CHANNEL_BITS);
	localparam int E_W    = (DIFF_W > cad_pkg::EDGE_W) ? DIFF_W : cad_pkg::EDGE_W;

	logic signed [DIFF_W-1:0] cfine;
	logic signed [XW-1:0]     crough;
	logic signed [E_W-1:0]    cf_e;
	logic signed [E_W-1:0]    lo_e;
	logic signed [E_W-1:0]    hi_e;
	logic                     in_win;
	logic                     below;
	logic                     above;
	cad_pkg::region_t         region_c;
	logic signed [XW-1:0]     x_c;
	logic                     accept;
	logic                     advance;

	logic                     valid_s1;
	cad_pkg::region_t         region_s1;
	logic signed [XW-1:0]     x_s1;

	// form the channel differences
	assign cfine  = DIFF_W'(channel_b) - DIFF_W'(channel_c);
	assign crough = XW'(channel_d) - XW'(channel_a) - XW'(rough_offset);

	// compare the fine difference against both edges at a common width
	assign cf_e = E_W'(cfine);
	assign lo_e = E_W'($signed(edge_bounds[cad_pkg::EDGE_W-1:0]));
	assign hi_e = E_W'($signed(edge_bounds[2*cad_pkg::EDGE_W-1:cad_pkg::EDGE_W]));

	assign in_win = (cf_e > lo_e) && (cf_e < hi_e);
	assign below  = curve_mode ? (cf_e <= lo_e) : (cf_e < lo_e);
	assign above  = curve_mode ? (cf_e >= hi_e) : (cf_e > hi_e);

	// classify: window tests first, then below, then above
	always_comb begin
		region_c = cad_pkg::RGN_NONE;
		x_c      = crough;
		if (in_win) begin
			x_c = XW'(cfine);
			if (crough > XW'(0)) begin
				region_c = cad_pkg::RGN_WIN_POS;
			end else if (crough < XW'(0)) begin
				region_c = cad_pkg::RGN_WIN_NEG;
			end
		end else if (below) begin
			region_c = cad_pkg::RGN_BELOW;
		end else if (above) begin
			region_c = cad_pkg::RGN_ABOVE;
		end
	end

	// hold the stage while the queue is full
	assign busy    = valid_s1 && q_full;
	assign advance = !busy;
	assign accept  = start && !busy;
	assign push    = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			region_s1 <= region_c;
			x_s1      <= x_c;
		end
	end

	assign region_out = region_s1;
	assign x_out      = x_s1;

endmodule

// ===== rtl/cad_queue.sv =====
// ----------------------------------------------------------------------------
// cad_queue : short queue between the front and back parts
// Two-entry first-in first-out buffer of classified items.
// ----------------------------------------------------------------------------
module cad_queue #(
	parameter int WIDTH = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int DEPTH = cad_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != CNT_W'(0));
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/cad_back.sv =====
// ----------------------------------------------------------------------------
// cad_back : curve evaluation pipeline of the capacitive angle decoder
// Five stages: square and linear products, split quadratic product, clamp,
// sum and round, turn correction and output saturation.
// ----------------------------------------------------------------------------
module cad_back #(
	parameter int CHANNEL_BITS = cad_pkg::CHANNEL_BITS_DEF,
	parameter int COEF_BITS    = cad_pkg::COEF_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	input  cad_pkg::region_t                          in_region,
	input  logic signed [cad_pkg::x_width(CHANNEL_BITS)-1:0] in_x,
	input  logic                                      curve_mode,
	input  logic signed [cad_pkg::BIAS_W-1:0]         output_bias,
	input  logic [3:0][3*COEF_BITS-1:0]               curve_sets,
	output logic                                      done,
	output logic signed [cad_pkg::ANGLE_W-1:0]        angle,
	output logic [cad_pkg::REGION_W-1:0]              region
);

	localparam int CW     = COEF_BITS;
	localparam int XW     = cad_pkg::x_width(CHANNEL_BITS);
	localparam int XX_W   = 2 * XW - 1;
	localparam int PX_W   = CW + XW;
	localparam int PL_W   = CW + XW + 1;
	localparam int PQ_W   = CW + 2 * XW;
	localparam int PLB    = cad_pkg::PROD_LIMIT_LOG2;
	localparam int CMP_W  = (PQ_W > PLB + 2) ? PQ_W : PLB + 2;
	localparam int TERM_W = (PQ_W < PLB + 2) ? PQ_W : PLB + 2;
	localparam int BT_W   = cad_pkg::BIAS_W + cad_pkg::ROUND_SHIFT;
	localparam int REST_W = ((PX_W + 1 > BT_W) ? PX_W + 1 : BT_W) + 2;
	localparam int S_W    = ((TERM_W > REST_W) ? TERM_W : REST_W) + 1;
	localparam int R_W    = S_W - cad_pkg::ROUND_SHIFT + 1;

	localparam logic signed [CMP_W-1:0] LIM_POS =
		{{(CMP_W-PLB-1){1'b0}}, 1'b1, {PLB{1'b0}}};
	localparam logic signed [CMP_W-1:0] LIM_NEG = -LIM_POS;

	// stage 1 signals
	logic signed [CW-1:0]     c0_c;
	logic signed [CW-1:0]     c1_c;
	logic signed [CW-1:0]     c2_c;
	logic signed [2*XW-1:0]   sq_c;
	logic signed [PX_W-1:0]   p0x_c;
	logic signed [PX_W-1:0]   p1x_c;
	logic                     valid_s1;
	cad_pkg::region_t         region_s1;
	logic signed [CW-1:0]     c0_s1;
	logic signed [CW-1:0]     c1_s1;
	logic signed [CW-1:0]     c2_s1;
	logic [XX_W-1:0]          xx_s1;
	logic signed [PX_W-1:0]   p0x_s1;
	logic signed [PX_W-1:0]   p1x_s1;

	// stage 2 signals
	logic signed [PL_W-1:0]   pl_c;
	logic signed [PX_W-1:0]   ph_c;
	logic signed [BT_W-1:0]   bias_term;
	logic signed [REST_W-1:0] rest_sel;
	logic                     valid_s2;
	cad_pkg::region_t         region_s2;
	logic signed [PL_W-1:0]   pl_s2;
	logic signed [PX_W-1:0]   ph_s2;
	logic signed [REST_W-1:0] rest_s2;

	// stage 3 signals
	logic signed [PQ_W-1:0]   pq_c;
	logic signed [CMP_W-1:0]  pq_e;
	logic signed [CMP_W-1:0]  pq_clamp;
	logic                     valid_s3;
	cad_pkg::region_t         region_s3;
	logic signed [TERM_W-1:0] term_s3;
	logic signed [REST_W-1:0] rest_s3;

	// stage 4 signals
	logic signed [S_W-1:0]    sum_c;
	logic                     valid_s4;
	cad_pkg::region_t         region_s4;
	logic signed [R_W-1:0]    r_s4;

	// stage 5 signals
	logic signed [R_W-1:0]    r_adj;
	logic signed [cad_pkg::ANGLE_W-1:0] angle_c;
	logic                     valid_s5;
	cad_pkg::region_t         region_s5;
	logic signed [cad_pkg::ANGLE_W-1:0] angle_s5;

	// pick the coefficient set named by the region; square the argument
	assign c0_c  = $signed(curve_sets[in_region[1:0]][CW-1:0]);
	assign c1_c  = $signed(curve_sets[in_region[1:0]][2*CW-1:CW]);
	assign c2_c  = $signed(curve_sets[in_region[1:0]][3*CW-1:2*CW]);
	assign sq_c  = in_x * in_x;
	assign p0x_c = PX_W'(c0_c) * PX_W'(in_x);
	assign p1x_c = PX_W'(c1_c) * PX_W'(in_x);

	// split the quadratic product over the two halves of the square
	assign pl_c = PL_W'(c0_s1) * $signed({1'b0, xx_s1[XW-1:0]});
	assign ph_c = PX_W'(c0_s1) * $signed({1'b0, xx_s1[XX_W-1:XW]});

	// bias in Q.12 plus the rounding half
	assign bias_term = $signed({output_bias, 1'b1, {(cad_pkg::ROUND_SHIFT-1){1'b0}}});

	always_comb begin
		if (curve_mode) begin
			rest_sel = REST_W'(p1x_s1) + REST_W'(c2_s1);
		end else begin
			rest_sel = REST_W'(p0x_s1) + REST_W'(c1_s1);
		end
	end

	// rejoin the halves and clamp the product
	assign pq_c = (PQ_W'(ph_s2) <<< XW) + PQ_W'(pl_s2);
	assign pq_e = CMP_W'(pq_c);

	always_comb begin
		if (pq_e > LIM_POS) begin
			pq_clamp = LIM_POS;
		end else if (pq_e < LIM_NEG) begin
			pq_clamp = LIM_NEG;
		end else begin
			pq_clamp = pq_e;
		end
	end

	// sum the terms
	assign sum_c = S_W'(term_s3) + S_W'(rest_s3);

	// lift negative below-window results by a full turn, then saturate; no region gives zero
	always_comb begin
		r_adj = r_s4;
		if ((region_s4 == cad_pkg::RGN_BELOW) && (r_s4 < R_W'(0))) begin
			r_adj = r_s4 + R_W'(cad_pkg::FULL_TURN);
		end
		if (region_s4 == cad_pkg::RGN_NONE) begin
			angle_c = '0;
		end else if (r_adj > R_W'(cad_pkg::ANGLE_MAX)) begin
			angle_c = cad_pkg::ANGLE_W'(cad_pkg::ANGLE_MAX);
		end else if (r_adj < R_W'(cad_pkg::ANGLE_MIN)) begin
			angle_c = cad_pkg::ANGLE_W'(cad_pkg::ANGLE_MIN);
		end else begin
			angle_c = r_adj[cad_pkg::ANGLE_W-1:0];
		end
	end

	// advance the valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// advance the datapath
	always_ff @(posedge clk) begin
		region_s1 <= in_region;
		c0_s1     <= c0_c;
		c1_s1     <= c1_c;
		c2_s1     <= c2_c;
		xx_s1     <= sq_c[XX_W-1:0];
		p0x_s1    <= p0x_c;
		p1x_s1    <= p1x_c;

		region_s2 <= region_s1;
		pl_s2     <= pl_c;
		ph_s2     <= ph_c;
		rest_s2   <= rest_sel + REST_W'(bias_term);

		region_s3 <= region_s2;
		term_s3   <= curve_mode ? TERM_W'(pq_clamp) : TERM_W'(0);
		rest_s3   <= rest_s2;

		region_s4 <= region_s3;
		r_s4      <= R_W'($signed(sum_c[S_W-1:cad_pkg::ROUND_SHIFT]));

		region_s5 <= region_s4;
		angle_s5  <= angle_c;
	end

	assign done   = valid_s5;
	assign angle  = angle_s5;
	assign region = region_s5;

endmodule

// ===== test/tb_capacitive_angle_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_capacitive_angle_decoder_core : self-checking bench for the angle decoder
// Drives register writes, and channel readings with random gaps. A scoreboard
// predicts angle and region for every accepted reading and checks each result
// in order, then the bench reports the overall verdict.
// ----------------------------------------------------------------------------
module tb_capacitive_angle_decoder_core;

	localparam int CH_W        = 16;
	localparam int CF_W        = 20;
	localparam int DATA_W      = cad_pkg::cfg_width(CF_W);
	localparam int WATCH_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 16;

	typedef struct {
		logic [cad_pkg::ANGLE_W-1:0] angle;
		cad_pkg::region_t            region;
	} angle_reading_t;

	// ------------------------------------------------------------------------
	// scoreboard: register shadow, angle prediction and in-order check
	// ------------------------------------------------------------------------
	class angle_scoreboard;
		bit             quad;
		longint         ofs;
		longint         lo;
		longint         hi;
		longint         bias;
		bit [DATA_W-1:0] sets [4];
		angle_reading_t expected_angles [$];
		int             errors;

		function new();
			quad   = 1'b0;
			ofs    = 0;
			lo     = 0;
			hi     = 0;
			bias   = 0;
			errors = 0;
			foreach (sets[i]) sets[i] = '0;
		endfunction

		function int pending();
			return expected_angles.size();
		endfunction

		// mirror a register write
		function void load_register(cad_pkg::cfg_idx_t idx, logic [DATA_W-1:0] v);
			case (idx)
				cad_pkg::CFG_CURVE_MODE:  quad = v[0];
				cad_pkg::CFG_ROUGH_OFS:   ofs  = $signed(v[cad_pkg::OFFSET_W-1:0]);
				cad_pkg::CFG_EDGE_BOUNDS: begin
					lo = $signed(v[cad_pkg::EDGE_W-1:0]);
					hi = $signed(v[2*cad_pkg::EDGE_W-1:cad_pkg::EDGE_W]);
				end
				cad_pkg::CFG_OUT_BIAS:    bias = $signed(v[cad_pkg::BIAS_W-1:0]);
				default: sets[int'(idx) - int'(cad_pkg::CFG_SET_ONE)] = v[3*CF_W-1:0];
			endcase
		endfunction

		// product clamped at +-2^60
		function longint limited_product(longint p, longint q);
			longint cap;
			longint r;
			cap = longint'(1) << cad_pkg::PROD_LIMIT_LOG2;
			r   = p * q;
			if (r > cap) r = cap;
			if (r < -cap) r = -cap;
			return r;
		endfunction

		function longint coef_of(bit [DATA_W-1:0] set, int k);
			logic signed [CF_W-1:0] c;
			c = set[k*CF_W +: CF_W];
			return c;
		endfunction

		// curve in Q.12 degrees, plus bias, rounded half up to 1/64 degree
		function longint curve_value(bit [DATA_W-1:0] set, longint x);
			longint s;
			if (quad)
				s = limited_product(coef_of(set, 0), limited_product(x, x))
					+ limited_product(coef_of(set, 1), x) + coef_of(set, 2);
			else
				s = limited_product(coef_of(set, 0), x) + coef_of(set, 1);
			s = s + bias * 64 + 32;
			return s >>> cad_pkg::ROUND_SHIFT;
		endfunction

		function angle_reading_t predict_angle(logic signed [CH_W-1:0] a,
				logic signed [CH_W-1:0] b, logic signed [CH_W-1:0] c,
				logic signed [CH_W-1:0] d);
			angle_reading_t r;
			longint fine;
			longint rough;
			longint ang;
			fine     = longint'(b) - longint'(c);
			rough    = longint'(d) - longint'(a) - ofs;
			ang      = 0;
			r.region = cad_pkg::RGN_NONE;
			if (fine > lo && fine < hi) begin
				if (rough > 0) begin
					ang      = curve_value(sets[0], fine);
					r.region = cad_pkg::RGN_WIN_POS;
				end else if (rough < 0) begin
					ang      = curve_value(sets[1], fine);
					r.region = cad_pkg::RGN_WIN_NEG;
				end
			end else if (quad ? fine <= lo : fine < lo) begin
				ang = curve_value(sets[2], rough);
				if (ang < 0) ang = ang + cad_pkg::FULL_TURN;
				r.region = cad_pkg::RGN_BELOW;
			end else if (quad ? fine >= hi : fine > hi) begin
				ang      = curve_value(sets[3], rough);
				r.region = cad_pkg::RGN_ABOVE;
			end
			if (ang > cad_pkg::ANGLE_MAX) ang = cad_pkg::ANGLE_MAX;
			if (ang < cad_pkg::ANGLE_MIN) ang = cad_pkg::ANGLE_MIN;
			r.angle = ang[cad_pkg::ANGLE_W-1:0];
			return r;
		endfunction

		function void note_reading(logic signed [CH_W-1:0] a, logic signed [CH_W-1:0] b,
				logic signed [CH_W-1:0] c, logic signed [CH_W-1:0] d);
			expected_angles.push_back(predict_angle(a, b, c, d));
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [cad_pkg::ANGLE_W-1:0] ang,
				logic [cad_pkg::REGION_W-1:0] rgn);
			angle_reading_t e;
			if (expected_angles.size() == 0) begin
				report($sformatf("result angle %0d region %0d with no reading pending",
					$signed(ang), rgn));
			end else begin
				e = expected_angles.pop_front();
				if (ang !== e.angle)
					report($sformatf("angle %0d, predicted %0d", $signed(ang),
						$signed(e.angle)));
				if (rgn !== e.region)
					report($sformatf("region %0d, predicted %0d", rgn, e.region));
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// signals and block under test
	// ------------------------------------------------------------------------
	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic signed [CH_W-1:0]              channel_a;
	logic signed [CH_W-1:0]              channel_b;
	logic signed [CH_W-1:0]              channel_c;
	logic signed [CH_W-1:0]              channel_d;
	logic                                done;
	logic signed [cad_pkg::ANGLE_W-1:0]  angle;
	logic [cad_pkg::REGION_W-1:0]        region;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [cad_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [DATA_W-1:0]                   cfg_data;

	angle_scoreboard sb;
	int              send_idle;

	capacitive_angle_decoder_core #(
		.CHANNEL_BITS(CH_W),
		.COEF_BITS   (CF_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.channel_a(channel_a),
		.channel_b(channel_b),
		.channel_c(channel_c),
		.channel_d(channel_d),
		.done     (done),
		.angle    (angle),
		.region   (region),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// free-running clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// check every result strobe
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(angle, region);
	end

	// ------------------------------------------------------------------------
	// drivers: all run from a falling edge and return on one
	// ------------------------------------------------------------------------
	function automatic logic [DATA_W-1:0] pack_set(int c0, int c1, int c2);
		logic [DATA_W-1:0] v;
		v = '0;
		v[CF_W-1:0]        = c0[CF_W-1:0];
		v[2*CF_W-1:CF_W]   = c1[CF_W-1:0];
		v[3*CF_W-1:2*CF_W] = c2[CF_W-1:0];
		return v;
	endfunction

	// random value of the given width, magnitude scattered by a random shift
	function automatic int scattered(int bits);
		int v;
		v = $urandom;
		v = (v <<< (32 - bits)) >>> (32 - bits);
		return v >>> $urandom_range(bits - 1, 0);
	endfunction

	// pick two channel codes whose difference is t (clamped to reach)
	function automatic void split_diff(input longint t, output logic signed [CH_W-1:0] upper,
			output logic signed [CH_W-1:0] lower);
		longint ymin;
		longint ymax;
		longint y;
		if (t > 65535) t = 65535;
		if (t < -65535) t = -65535;
		ymin  = (t > 0) ? -32768 : -32768 - t;
		ymax  = (t > 0) ? 32767 - t : 32767;
		y     = ymin + longint'($urandom_range(32'(ymax - ymin), 0));
		lower = y[CH_W-1:0];
		upper = CH_W'(y + t);
	endfunction

	task write_register(cad_pkg::cfg_idx_t idx, logic [DATA_W-1:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.load_register(idx, v);
		@(negedge clk);
	endtask

	// drain, then load every register
	task configure(bit mode, int ofs, int lo, int hi, int bias,
			logic [DATA_W-1:0] s1, logic [DATA_W-1:0] s2,
			logic [DATA_W-1:0] s3, logic [DATA_W-1:0] s4);
		logic [DATA_W-1:0] edges;
		start = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		edges = '0;
		edges[cad_pkg::EDGE_W-1:0]                 = lo[cad_pkg::EDGE_W-1:0];
		edges[2*cad_pkg::EDGE_W-1:cad_pkg::EDGE_W] = hi[cad_pkg::EDGE_W-1:0];
		write_register(cad_pkg::CFG_CURVE_MODE, DATA_W'(mode));
		write_register(cad_pkg::CFG_ROUGH_OFS, DATA_W'(ofs[cad_pkg::OFFSET_W-1:0]));
		write_register(cad_pkg::CFG_EDGE_BOUNDS, edges);
		write_register(cad_pkg::CFG_OUT_BIAS, DATA_W'(bias[cad_pkg::BIAS_W-1:0]));
		write_register(cad_pkg::CFG_SET_ONE, s1);
		write_register(cad_pkg::CFG_SET_TWO, s2);
		write_register(cad_pkg::CFG_SET_THREE, s3);
		write_register(cad_pkg::CFG_SET_FOUR, s4);
		cfg_valid = 1'b0;
	endtask

	// hold start until the reading is taken; idle at random before it
	task send_reading(logic signed [CH_W-1:0] a, logic signed [CH_W-1:0] b,
			logic signed [CH_W-1:0] c, logic signed [CH_W-1:0] d);
		while ($urandom_range(99, 0) < send_idle) begin
			start = 1'b0;
			@(negedge clk);
		end
		start     = 1'b1;
		channel_a = a;
		channel_b = b;
		channel_c = c;
		channel_d = d;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_reading(a, b, c, d);
		@(negedge clk);
	endtask

	// reading with a chosen fine difference and rough difference
	task send_shaped(longint fine, longint rough);
		logic signed [CH_W-1:0] a;
		logic signed [CH_W-1:0] b;
		logic signed [CH_W-1:0] c;
		logic signed [CH_W-1:0] d;
		split_diff(fine, b, c);
		split_diff(rough + sb.ofs, d, a);
		send_reading(a, b, c, d);
	endtask

	task random_setup();
		int ofs;
		int lo;
		int hi;
		int bias;
		int pick;
		logic [DATA_W-1:0] s [4];
		case ($urandom_range(7, 0))
			0:       ofs = -65536;
			1:       ofs = 65535;
			default: ofs = scattered(cad_pkg::OFFSET_W);
		endcase
		pick = $urandom_range(7, 0);
		if (pick == 0) begin
			lo = scattered(cad_pkg::EDGE_W);
			hi = scattered(cad_pkg::EDGE_W);
		end else if (pick == 1) begin
			lo = -131072;
			hi = 131071;
		end else begin
			lo = int'($urandom_range(60000, 0)) - 40000;
			hi = lo + int'($urandom_range(60000, 0));
		end
		case ($urandom_range(7, 0))
			0:       bias = cad_pkg::ANGLE_MIN;
			1:       bias = cad_pkg::ANGLE_MAX;
			default: bias = scattered(cad_pkg::BIAS_W);
		endcase
		foreach (s[i]) s[i] = pack_set(scattered(CF_W), scattered(CF_W), scattered(CF_W));
		configure(1'($urandom_range(1, 0)), ofs, lo, hi, bias, s[0], s[1], s[2], s[3]);
	endtask

	// half free readings, half aimed at the edges and the rough sign
	task random_reading();
		longint fine;
		longint rough;
		if ($urandom_range(1, 0)) begin
			send_reading(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
				CH_W'($urandom));
		end else begin
			case ($urandom_range(5, 0))
				0: fine = sb.lo;
				1: fine = sb.hi;
				2: fine = sb.lo + 1;
				3: fine = sb.hi - 1;
				4: fine = (sb.lo < sb.hi) ?
					sb.lo + longint'($urandom_range(32'(sb.hi - sb.lo), 0)) : sb.lo;
				default: fine = longint'($urandom_range(131070, 0)) - 65535;
			endcase
			case ($urandom_range(3, 0))
				0:       rough = 0;
				1:       rough = longint'($urandom_range(600, 0)) - 300;
				default: rough = longint'($urandom_range(131070, 0)) - 65535;
			endcase
			send_shaped(fine, rough);
		end
	endtask

	// ------------------------------------------------------------------------
	// watchdog: end the run when nothing transfers for too long
	// ------------------------------------------------------------------------
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCH_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		int p;
		sb        = new();
		send_idle = 20;
		arst_n    = 1'b0;
		start     = 1'b0;
		channel_a = '0;
		channel_b = '0;
		channel_c = '0;
		channel_d = '0;
		cfg_valid = 1'b0;
		cfg_index = cad_pkg::CFG_CURVE_MODE;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero edges, region below, above or none from the sign of fine
		send_shaped(-1, 5);
		send_shaped(1, -5);
		send_shaped(0, 0);

		// linear: both window curves, rough zero, edge hits, negative below
		configure(1'b0, 100, -1000, 1000, -5, pack_set(4096, 256, 0),
			pack_set(-4096, -256, 0), pack_set(-8192, 0, 0), pack_set(2048, 4096, 0));
		send_shaped(0, 500);
		send_shaped(500, -500);
		send_shaped(200, 0);
		send_shaped(-1000, 300);
		send_shaped(1000, 300);
		send_shaped(-5000, 30);
		send_shaped(5000, -3000);
		send_reading(CH_W'(-32768), CH_W'(32767), CH_W'(-32768), CH_W'(32767));
		send_reading(CH_W'(32767), CH_W'(-32768), CH_W'(32767), CH_W'(-32768));

		// quadratic: inclusive edges, extreme coefficients, bias at the top
		configure(1'b1, -65536, -2000, 2000, cad_pkg::ANGLE_MAX,
			pack_set(-524288, -1, 524287),
			pack_set(524287, 524287, -524288), pack_set(-524288, 524287, -524288),
			pack_set(524287, -524288, 524287));
		send_shaped(-2000, 10);
		send_shaped(2000, 10);
		send_shaped(0, 1);
		send_shaped(0, -1);
		send_reading(CH_W'(0), CH_W'(0), CH_W'(0), CH_W'(0));
		send_reading(CH_W'(-1), CH_W'(-1), CH_W'(-1), CH_W'(-1));

		// crossed edges at the ends of their range, bias at the bottom
		configure(1'b0, 65535, 131071, -131072, cad_pkg::ANGLE_MIN,
			pack_set(-524288, -524288, 0),
			pack_set(524287, 524287, 0), pack_set(-524288, -524288, -1),
			pack_set(524287, 524287, -1));
		send_shaped(0, 0);
		send_shaped(65535, -65535);
		send_shaped(-65535, 65535);

		// random settings and readings under three idling profiles
		for (p = 0; p < 9; p++) begin
			send_idle = (p < 3) ? 20 : (p < 6) ? 62 : 0;
			random_setup();
			repeat (190) random_reading();
		end

		// drain and give verdict
		start = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== capacitive_angle_decoder_core.f =====
rtl/cad_pkg.sv
rtl/cad_front.sv
rtl/cad_queue.sv
rtl/cad_back.sv
rtl/capacitive_angle_decoder_core.sv
test/tb_capacitive_angle_decoder_core.sv
